// ===== sv/rvx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared types, opcodes and status codes of the execute unit.
// ----------------------------------------------------------------------------
package rvx_pkg;

	localparam int unsigned DataMemBytesDef = 65536;

	localparam logic [6:0] OP_RTYPE  = 7'h33;
	localparam logic [6:0] OP_ITYPE  = 7'h13;
	localparam logic [6:0] OP_SYSTEM = 7'h73;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_JAL    = 7'h6F;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_LUI    = 7'h37;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;
	localparam logic [6:0] F7_MUL  = 7'h01;

	localparam logic [31:0] A0_PRINT_INT  = 32'd1;
	localparam logic [31:0] A0_EXIT       = 32'd10;
	localparam logic [31:0] A0_PRINT_CHAR = 32'd11;

	localparam logic [4:0] REG_A0 = 5'd10;
	localparam logic [4:0] REG_A1 = 5'd11;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_INVALID    = 3'd1,
		ST_EXIT       = 3'd2,
		ST_PRINT_INT  = 3'd3,
		ST_PRINT_CHAR = 3'd4,
		ST_ILLEGAL    = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_EXEC,
		S_DIV,
		S_MEM,
		S_WB,
		S_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic read_regs;
		logic exec;
		logic div_start;
		logic div_step;
		logic mem_step;
		logic commit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_preload;
		logic is_div;
		logic is_mem;
		logic div_done;
		logic mem_done;
	} dp_sts_t;

endpackage

// ===== sv/rvx_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx_datapath
// Register file, PC, byte memory, ALU, multiplier and radix-2 divider.
// ----------------------------------------------------------------------------
module rvx_datapath #(
	parameter int unsigned DATA_MEM_BYTES = rvx_pkg::DataMemBytesDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start_pc_we,
	input  logic [31:0]         start_pc,
	input  logic                func,
	input  logic [31:0]         instruction_word,
	input  logic [15:0]         preload_address,
	input  rvx_pkg::dp_cmd_t    cmd,
	output rvx_pkg::dp_sts_t    sts,
	output logic [2:0]          status,
	output logic [31:0]         next_pc,
	output logic [4:0]          dest_register,
	output logic [31:0]         result_value
);
	import rvx_pkg::*;

	localparam int unsigned AW = $clog2(DATA_MEM_BYTES);

	logic [31:0] regs_q [1:31];
	logic [31:0] pc_q;
	logic        halted_q;
	logic [7:0]  mem [DATA_MEM_BYTES];

	logic        func_q;
	logic [31:0] ins_q;
	logic [15:0] pl_addr_q;
	logic [31:0] a_q, b_q, a0_q, a1_q;

	logic [6:0] op, f7;
	logic [2:0] f3;
	logic [4:0] rdf, rs1, rs2;
	assign op  = ins_q[6:0];
	assign rdf = ins_q[11:7];
	assign f3  = ins_q[14:12];
	assign rs1 = ins_q[19:15];
	assign rs2 = ins_q[24:20];
	assign f7  = ins_q[31:25];

	logic [31:0] imm_i, imm_s, imm_b, imm_j;
	assign imm_i = {{20{ins_q[31]}}, ins_q[31:20]};
	assign imm_s = {{20{ins_q[31]}}, ins_q[31:25], ins_q[11:7]};
	assign imm_b = {{19{ins_q[31]}}, ins_q[31], ins_q[7], ins_q[30:25], ins_q[11:8], 1'b0};
	assign imm_j = {{11{ins_q[31]}}, ins_q[31], ins_q[19:12], ins_q[20], ins_q[30:21], 1'b0};

	// decode
	logic is_div, is_load, is_store, is_mul;
	assign is_mul   = (op == OP_RTYPE) && (f7 == F7_MUL) && (f3 == 3'd0 || f3 == 3'd1);
	assign is_div   = (op == OP_RTYPE) && (f7 == F7_MUL) && f3[2];
	assign is_load  = (op == OP_LOAD) && (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd2
		|| f3 == 3'd4 || f3 == 3'd5);
	assign is_store = (op == OP_STORE) && (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd2);

	assign sts.is_preload = func_q;
	assign sts.is_div     = is_div && !halted_q;
	assign sts.is_mem     = (is_load || is_store) && !halted_q;

	// ALU, combinational
	logic [31:0] alu_r;
	logic        alu_ok;
	logic [4:0]  shamt;
	logic [31:0] opb;
	always_comb begin
		alu_r  = '0;
		alu_ok = 1'b1;
		opb    = (op == OP_ITYPE) ? imm_i : b_q;
		shamt  = opb[4:0];
		unique case (f3)
			3'd0: alu_r = (op == OP_RTYPE && f7 == F7_ALT) ? a_q - opb : a_q + opb;
			3'd1: alu_r = a_q << shamt;
			3'd2: alu_r = {31'd0, $signed(a_q) < $signed(opb)};
			3'd3: alu_r = {31'd0, a_q < opb};
			3'd4: alu_r = a_q ^ opb;
			3'd5: alu_r = f7[5] ? 32'($signed(a_q) >>> shamt) : a_q >> shamt;
			3'd6: alu_r = a_q | opb;
			3'd7: alu_r = a_q & opb;
			default: alu_r = '0;
		endcase
		if (op == OP_RTYPE) begin
			if (f7 == F7_BASE) alu_ok = 1'b1;
			else if (f7 == F7_ALT) alu_ok = (f3 == 3'd0 || f3 == 3'd5);
			else alu_ok = 1'b0;
		end else begin
			priority case (f3)
				3'd3: alu_ok = 1'b0;
				3'd1: alu_ok = (f7 == F7_BASE);
				3'd5: alu_ok = (f7 == F7_BASE || f7 == F7_ALT);
				default: alu_ok = 1'b1;
			endcase
		end
	end

	// multiplier: 33x33 signed, high or low word
	logic signed [65:0] prod;
	assign prod = $signed({a_q[31], a_q}) * $signed({b_q[31], b_q});

	// restoring divider, one quotient bit per cycle
	logic [31:0] dq_q, rem_q, dvs_q;
	logic [5:0]  dcnt_q;
	logic        neg_q_q, neg_r_q;
	logic        dsigned;
	logic [32:0] trial;
	assign dsigned = !f3[0];
	assign trial   = {rem_q, dq_q[31]} - {1'b0, dvs_q};
	assign sts.div_done = dcnt_q[5];
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dq_q    <= (dsigned && a_q[31]) ? -a_q : a_q;
			dvs_q   <= (dsigned && b_q[31]) ? -b_q : b_q;
			rem_q   <= '0;
			dcnt_q  <= '0;
			neg_q_q <= dsigned && (a_q[31] ^ b_q[31]);
			neg_r_q <= dsigned && a_q[31];
		end else if (cmd.div_step && !dcnt_q[5]) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				dq_q  <= {dq_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], dq_q[31]};
				dq_q  <= {dq_q[30:0], 1'b0};
			end
			dcnt_q <= dcnt_q + 6'd1;
		end
	end
	logic [31:0] div_r;
	always_comb begin
		if (b_q == '0) div_r = f3[1] ? a_q : '1;
		else if (f3[1]) div_r = neg_r_q ? -rem_q : rem_q;
		else div_r = neg_q_q ? -dq_q : dq_q;
	end

	// memory: one byte per cycle, four steps
	logic [31:0] maddr;
	logic [1:0]  mcnt_q;
	logic [31:0] ld_q;
	logic [7:0]  rd_byte_q;
	logic        rd_vld_q;
	logic [1:0]  rd_idx_q;
	logic [2:0]  nbytes;
	logic [AW-1:0] widx;
	logic [7:0]  wbyte;
	logic        wen;
	assign maddr  = a_q + (is_store ? imm_s : imm_i);
	assign nbytes = (f3[1:0] == 2'd0) ? 3'd1 : (f3[1:0] == 2'd1) ? 3'd2 : 3'd4;
	assign sts.mem_done = (mcnt_q == 2'd3);

	always_comb begin
		wen   = 1'b0;
		widx  = '0;
		wbyte = '0;
		if (cmd.mem_step) begin
			if (func_q) begin
				wen   = 1'b1;
				widx  = AW'(32'(pl_addr_q) + 32'(mcnt_q));
				wbyte = ins_q[8*mcnt_q +: 8];
			end else begin
				wen   = is_store && ({1'b0, mcnt_q} < nbytes);
				widx  = AW'(maddr + 32'(mcnt_q));
				wbyte = b_q[8*mcnt_q +: 8];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wen) mem[widx] <= wbyte;
		rd_byte_q <= mem[AW'(maddr + 32'(mcnt_q))];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcnt_q   <= '0;
			rd_vld_q <= 1'b0;
			rd_idx_q <= '0;
		end else begin
			rd_vld_q <= cmd.mem_step && !func_q;
			rd_idx_q <= mcnt_q;
			if (cmd.mem_step) mcnt_q <= mcnt_q + 2'd1;
			else if (cmd.capture) mcnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) ld_q <= '0;
		else if (rd_vld_q) ld_q[8*rd_idx_q +: 8] <= rd_byte_q;
	end

	// merge the last byte, still in the read register at commit
	logic [31:0] ld_w;
	always_comb begin
		ld_w = ld_q;
		if (rd_vld_q) ld_w[8*rd_idx_q +: 8] = rd_byte_q;
	end

	logic [31:0] ld_r;
	always_comb begin
		unique case (f3)
			3'd0: ld_r = {{24{ld_w[7]}}, ld_w[7:0]};
			3'd1: ld_r = {{16{ld_w[15]}}, ld_w[15:0]};
			3'd4: ld_r = {24'd0, ld_w[7:0]};
			3'd5: ld_r = {16'd0, ld_w[15:0]};
			default: ld_r = ld_w;
		endcase
	end

	// operand capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q    <= func;
			ins_q     <= instruction_word;
			pl_addr_q <= preload_address;
		end
		if (cmd.read_regs) begin
			a_q  <= (rs1 == '0) ? '0 : regs_q[rs1];
			b_q  <= (rs2 == '0) ? '0 : regs_q[rs2];
			a0_q <= regs_q[REG_A0];
			a1_q <= regs_q[REG_A1];
		end
	end

	// result staging
	logic [31:0] r_q;
	logic        wr_q, ok_q;
	logic [31:0] fast_r;
	logic        fast_wr, fast_ok;
	always_comb begin
		fast_r  = '0;
		fast_wr = 1'b0;
		fast_ok = 1'b1;
		unique case (op)
			OP_RTYPE: begin
				if (f7 == F7_MUL) begin
					fast_ok = is_mul || is_div;
					fast_r  = (f3 == 3'd1) ? prod[63:32] : prod[31:0];
				end else begin
					fast_ok = alu_ok;
					fast_r  = alu_r;
				end
				fast_wr = fast_ok;
			end
			OP_ITYPE: begin
				fast_ok = alu_ok;
				fast_r  = alu_r;
				fast_wr = alu_ok;
			end
			OP_LOAD: begin
				fast_ok = is_load;
				fast_wr = is_load;
			end
			OP_STORE:  fast_ok = is_store;
			OP_BRANCH: fast_ok = (f3 == 3'd0 || f3 == 3'd1);
			OP_JAL: begin
				fast_r  = pc_q + 32'd4;
				fast_wr = 1'b1;
			end
			OP_LUI: begin
				fast_r  = {ins_q[31:12], 12'd0};
				fast_wr = 1'b1;
			end
			OP_SYSTEM: fast_ok = 1'b1;
			default:   fast_ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			r_q  <= fast_r;
			wr_q <= fast_wr;
			ok_q <= fast_ok;
		end
	end

	// commit
	logic [31:0] fin_r, nxt;
	logic [2:0]  st;
	logic        halt_set, do_wr;
	always_comb begin
		fin_r    = is_div ? div_r : (is_load ? ld_r : r_q);
		st       = ST_OK;
		nxt      = pc_q + 32'd4;
		halt_set = 1'b0;
		do_wr    = 1'b0;
		if (func_q) begin
			nxt = pc_q;
		end else if (halted_q) begin
			st  = ST_EXIT;
			nxt = pc_q;
		end else if (!ok_q) begin
			st       = ST_INVALID;
			nxt      = pc_q;
			halt_set = 1'b1;
		end else begin
			do_wr = wr_q && (rdf != '0);
			if (op == OP_BRANCH) begin
				if ((a_q == b_q) ^ f3[0]) nxt = pc_q + imm_b;
			end else if (op == OP_JAL) begin
				nxt = pc_q + imm_j;
			end else if (op == OP_SYSTEM) begin
				if (a0_q == A0_PRINT_INT) st = ST_PRINT_INT;
				else if (a0_q == A0_PRINT_CHAR) st = ST_PRINT_CHAR;
				else begin
					st       = (a0_q == A0_EXIT) ? ST_EXIT : ST_ILLEGAL;
					nxt      = pc_q;
					halt_set = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= '0;
			halted_q <= 1'b0;
			for (int i = 1; i < 32; i++) regs_q[i] <= '0;
		end else begin
			if (start_pc_we) pc_q <= start_pc;
			else if (cmd.commit) begin
				pc_q <= nxt;
				if (halt_set) halted_q <= 1'b1;
				if (do_wr) regs_q[rdf] <= fin_r;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status        <= st;
			next_pc       <= nxt;
			dest_register <= do_wr ? rdf : '0;
			if (do_wr) result_value <= fin_r;
			else if (!func_q && !halted_q && ok_q && op == OP_SYSTEM
				&& (st == ST_PRINT_INT || st == ST_PRINT_CHAR)) result_value <= a1_q;
			else result_value <= '0;
		end
	end

endmodule

// ===== sv/rvx_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx_ctrl
// Sequencer: capture, register read, execute (skipped for preloads), divide or memory, commit, output.
// ----------------------------------------------------------------------------
module rvx_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  rvx_pkg::dp_sts_t sts,
	output rvx_pkg::dp_cmd_t cmd
);
	import rvx_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_READ;
			S_READ: state_d = sts.is_preload ? S_MEM : S_EXEC;
			S_EXEC: begin
				if (sts.is_div) state_d = S_DIV;
				else if (sts.is_mem) state_d = S_MEM;
				else state_d = S_WB;
			end
			S_DIV: if (sts.div_done) state_d = S_WB;
			S_MEM: if (sts.mem_done) state_d = S_WB;
			S_WB:  state_d = S_OUT;
			S_OUT: if (!out_stall) state_d = in_valid ? S_READ : S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			S_READ: cmd.read_regs = 1'b1;
			S_EXEC: begin
				cmd.exec      = 1'b1;
				cmd.div_start = 1'b1;
			end
			S_DIV: cmd.div_step = 1'b1;
			S_MEM: cmd.mem_step = 1'b1;
			S_WB:  cmd.commit = 1'b1;
			S_OUT: begin
				out_valid   = 1'b1;
				in_stall    = out_stall;
				cmd.capture = in_valid && !out_stall;
			end
			default: ;
		endcase
	end

endmodule

// ===== sv/rv32im_subset_execute_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32im_subset_execute_unit
// Executes one RV32IM subset instruction or preloads one memory word per word.
// ----------------------------------------------------------------------------
// One word at a time: ALU, multiply, branch, jump, LUI and ecall pass through the
// register read, execute, commit and output states; loads and stores add a memory
// state (one data-memory byte per cycle) and preloads go from register read to
// memory with no execute step; divide and remainder add a divide state (the radix-2
// divider retires one quotient bit per cycle). A new word is taken in the same cycle
// that the result is taken. The data memory has no reset; the register file, PC and
// halt flag reset at once. Writing start_pc also loads the PC.
module rv32im_subset_execute_unit #(
	parameter int unsigned DATA_MEM_BYTES = rvx_pkg::DataMemBytesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [31:0] instruction_word,
	input  logic [15:0] preload_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] next_pc,
	output logic [4:0]  dest_register,
	output logic [31:0] result_value
);
	import rvx_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	rvx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rvx_datapath #(
		.DATA_MEM_BYTES (DATA_MEM_BYTES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.start_pc_we      (cfg_we),
		.start_pc         (cfg_wdata),
		.func             (func),
		.instruction_word (instruction_word),
		.preload_address  (preload_address),
		.cmd              (cmd),
		.sts              (sts),
		.status           (status),
		.next_pc          (next_pc),
		.dest_register    (dest_register),
		.result_value     (result_value)
	);

endmodule

// ===== tb/sv/tb_rv32im_subset_execute_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rv32im_subset_execute_unit
// Runs directed and random instruction and preload words through the execute
// unit and checks each result word against an in-bench instruction predictor.
// ----------------------------------------------------------------------------
module tb_rv32im_subset_execute_unit;
	import rvx_pkg::*;

	localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR = 3'd4, F3_SRL = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;
	localparam logic [2:0] F3_MUL = 3'd0, F3_MULH = 3'd1, F3_DIV = 3'd4, F3_DIVU = 3'd5;
	localparam logic [2:0] F3_REM = 3'd6, F3_REMU = 3'd7;
	localparam logic [2:0] F3_LB = 3'd0, F3_LH = 3'd1, F3_LW = 3'd2, F3_LBU = 3'd4;
	localparam logic [2:0] F3_LHU = 3'd5;
	localparam logic [2:0] F3_SB = 3'd0, F3_SH = 3'd1, F3_SW = 3'd2;
	localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1;
	localparam logic [31:0] A0_PRINT_STR = 32'd4;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] next_pc;
		logic [4:0]  rd;
		logic [31:0] value;
	} exec_result_t;

	class exec_scoreboard;
		logic [31:0]  regs [32];
		logic [31:0]  pc;
		logic [7:0]   mem [65536];
		bit           mem_written [65536];
		bit           halted;
		exec_result_t pending_results [$];
		int           mismatches;

		function new();
			foreach (regs[i]) regs[i] = '0;
			pc = '0;
			halted = 0;
			mismatches = 0;
		endfunction

		function void load_start_pc(logic [31:0] v);
			pc = v;
		endfunction

		function logic [31:0] mem_read(logic [31:0] ad, int n);
			logic [31:0] v;
			v = '0;
			for (int i = 0; i < n; i++)
				v |= 32'(mem[16'(ad + i)]) << (8 * i);
			return v;
		endfunction

		function void mem_write(logic [31:0] ad, int n, logic [31:0] v);
			for (int i = 0; i < n; i++) begin
				mem[16'(ad + i)] = v[8*i +: 8];
				mem_written[16'(ad + i)] = 1;
			end
		endfunction

		// predict the result of one accepted word
		function void note(logic fn, logic [31:0] ins, logic [15:0] pa);
			exec_result_t e;
			logic [31:0] a, b, r, imm, nxt;
			logic [63:0] wide;
			logic [6:0]  f7;
			logic [2:0]  f3;
			logic [4:0]  rdf;
			bit ok, wr;
			a = regs[ins[19:15]];
			b = regs[ins[24:20]];
			f7 = ins[31:25];
			f3 = ins[14:12];
			rdf = ins[11:7];
			nxt = pc + 4;
			r = '0;
			ok = 1;
			wr = 0;
			e = '{status: ST_OK, next_pc: 0, rd: 0, value: 0};
			if (fn) begin
				mem_write({16'h0, pa}, 4, ins);
				nxt = pc;
			end else if (halted) begin
				e.status = ST_EXIT;
				nxt = pc;
			end else begin
				case (ins[6:0])
					OP_RTYPE: begin
						wr = 1;
						if (f7 == F7_BASE) begin
							case (f3)
								F3_ADD:  r = a + b;
								F3_SLL:  r = a << b[4:0];
								F3_SLT:  r = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
								F3_SLTU: r = (a < b) ? 32'd1 : 32'd0;
								F3_XOR:  r = a ^ b;
								F3_SRL:  r = a >> b[4:0];
								F3_OR:   r = a | b;
								default: r = a & b;
							endcase
						end else if (f7 == F7_ALT && f3 == F3_ADD) begin
							r = a - b;
						end else if (f7 == F7_ALT && f3 == F3_SRL) begin
							r = $signed(a) >>> b[4:0];
						end else if (f7 == F7_MUL) begin
							case (f3)
								F3_MUL: r = a * b;
								F3_MULH: begin
									wide = longint'($signed(a)) * longint'($signed(b));
									r = wide[63:32];
								end
								F3_DIV: begin
									if (b == 0) r = '1;
									else if (a == 32'h8000_0000 && b == '1) r = a;
									else begin
										wide = longint'($signed(a)) / longint'($signed(b));
										r = wide[31:0];
									end
								end
								F3_DIVU: r = (b == 0) ? '1 : a / b;
								F3_REM: begin
									if (b == 0) r = a;
									else if (a == 32'h8000_0000 && b == '1) r = '0;
									else begin
										wide = longint'($signed(a)) % longint'($signed(b));
										r = wide[31:0];
									end
								end
								F3_REMU: r = (b == 0) ? a : a % b;
								default: ok = 0;
							endcase
						end else ok = 0;
					end
					OP_ITYPE: begin
						wr = 1;
						imm = {{20{ins[31]}}, ins[31:20]};
						case (f3)
							F3_ADD: r = a + imm;
							F3_SLL: if (f7 == F7_BASE) r = a << ins[24:20]; else ok = 0;
							F3_SLT: r = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0;
							F3_XOR: r = a ^ imm;
							F3_SRL: begin
								if (f7 == F7_BASE) r = a >> ins[24:20];
								else if (f7 == F7_ALT) r = $signed(a) >>> ins[24:20];
								else ok = 0;
							end
							F3_OR:  r = a | imm;
							F3_AND: r = a & imm;
							default: ok = 0;
						endcase
					end
					OP_LOAD: begin
						wr = 1;
						imm = a + {{20{ins[31]}}, ins[31:20]};
						case (f3)
							F3_LB:  r = {{24{mem[16'(imm)][7]}}, mem[16'(imm)]};
							F3_LH: begin
								r = mem_read(imm, 2);
								r = {{16{r[15]}}, r[15:0]};
							end
							F3_LW:  r = mem_read(imm, 4);
							F3_LBU: r = mem_read(imm, 1);
							F3_LHU: r = mem_read(imm, 2);
							default: ok = 0;
						endcase
					end
					OP_STORE: begin
						imm = a + {{20{ins[31]}}, ins[31:25], ins[11:7]};
						case (f3)
							F3_SB: mem_write(imm, 1, b);
							F3_SH: mem_write(imm, 2, b);
							F3_SW: mem_write(imm, 4, b);
							default: ok = 0;
						endcase
					end
					OP_BRANCH: begin
						imm = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
						if (f3 == F3_BEQ) begin
							if (a == b) nxt = pc + imm;
						end else if (f3 == F3_BNE) begin
							if (a != b) nxt = pc + imm;
						end else ok = 0;
					end
					OP_JAL: begin
						imm = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
						r = pc + 4;
						wr = 1;
						nxt = pc + imm;
					end
					OP_LUI: begin
						r = {ins[31:12], 12'h0};
						wr = 1;
					end
					OP_SYSTEM: begin
						if (regs[REG_A0] == A0_PRINT_INT) begin
							e.status = ST_PRINT_INT;
							e.value = regs[REG_A1];
						end else if (regs[REG_A0] == A0_PRINT_CHAR) begin
							e.status = ST_PRINT_CHAR;
							e.value = regs[REG_A1];
						end else begin
							e.status = (regs[REG_A0] == A0_EXIT) ? ST_EXIT : ST_ILLEGAL;
							halted = 1;
							nxt = pc;
						end
					end
					default: ok = 0;
				endcase
				if (!ok) begin
					e.status = ST_INVALID;
					halted = 1;
					nxt = pc;
					wr = 0;
				end
				if (wr && rdf != 0) begin
					regs[rdf] = r;
					e.rd = rdf;
					e.value = r;
				end
				pc = nxt;
			end
			e.next_pc = nxt;
			pending_results.push_back(e);
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
		endfunction

		function void check(exec_result_t got);
			exec_result_t e;
			if (pending_results.size() == 0) begin
				flag($sformatf("unexpected result word %p", got));
				return;
			end
			e = pending_results.pop_front();
			if (got.status !== e.status)
				flag($sformatf("status exp %0d got %0d", e.status, got.status));
			if (got.next_pc !== e.next_pc)
				flag($sformatf("next_pc exp %h got %h", e.next_pc, got.next_pc));
			if (got.rd !== e.rd)
				flag($sformatf("dest_register exp %0d got %0d", e.rd, got.rd));
			if (got.value !== e.value)
				flag($sformatf("result_value exp %h got %h", e.value, got.value));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic        func;
	logic [31:0] instruction_word;
	logic [15:0] preload_address;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [31:0] next_pc;
	logic [4:0]  dest_register;
	logic [31:0] result_value;

	exec_scoreboard sb;
	int send_idle_pct;
	int stall_pct;
	bit hold_req;
	int quiet_cycles;

	rv32im_subset_execute_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .func(func),
		.instruction_word(instruction_word), .preload_address(preload_address),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.next_pc(next_pc), .dest_register(dest_register), .result_value(result_value)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3, logic [4:0] rd);
		return {f7, rs2, rs1, f3, rd, OP_RTYPE};
	endfunction

	function automatic logic [31:0] enc_i(logic [6:0] op, logic [11:0] imm, logic [4:0] rs1,
			logic [2:0] f3, logic [4:0] rd);
		return {imm, rs1, f3, rd, op};
	endfunction

	function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3);
		return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
	endfunction

	function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3);
		return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
	endfunction

	function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
		return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
	endfunction

	function automatic logic [31:0] enc_lui(logic [19:0] imm, logic [4:0] rd);
		return {imm, rd, OP_LUI};
	endfunction

	function automatic logic [31:0] ecall_word();
		logic [31:0] w;
		w = $urandom;
		return {w[31:7], OP_SYSTEM};
	endfunction

	function automatic logic [4:0] pick_reg();
		return ($urandom_range(1) == 1) ? 5'($urandom_range(7)) : 5'($urandom_range(31));
	endfunction

	// immediates lean toward their extremes
	function automatic logic [11:0] pick_imm12();
		case ($urandom_range(5))
			0: return 12'hFFF;
			1: return 12'h800;
			2: return 12'h7FF;
			3: return 12'h000;
			default: return 12'($urandom);
		endcase
	endfunction

	task automatic send(logic fn, logic [31:0] word, logic [15:0] pa);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		func <= fn;
		instruction_word <= word;
		preload_address <= pa;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		sb.note(fn, word, pa);
	endtask

	// loads only touch bytes that were written: preload the missing ones first
	task automatic exec(logic [31:0] word);
		logic [31:0] ad;
		logic [15:0] byte_ad;
		if (word[6:0] == OP_LOAD && !sb.halted) begin
			ad = sb.regs[word[19:15]] + {{20{word[31]}}, word[31:20]};
			for (int i = 0; i < 4; i++) begin
				byte_ad = 16'(ad + i);
				if (!sb.mem_written[byte_ad])
					send(1, $urandom, byte_ad & 16'hFFFC);
			end
		end
		send(0, word, 16'($urandom));
	endtask

	task automatic random_word();
		logic [6:0] f7;
		logic [2:0] f3;
		int k;
		k = $urandom_range(99);
		if (k < 8) begin
			send(1, $urandom, 16'($urandom_range(65532)));
		end else if (k < 36) begin
			case ($urandom_range(2))
				0: f7 = F7_BASE;
				1: f7 = F7_ALT;
				default: f7 = F7_MUL;
			endcase
			f3 = 3'($urandom);
			if (f7 == F7_ALT) f3 = ($urandom_range(1) == 1) ? F3_SRL : F3_ADD;
			if (f7 == F7_MUL && (f3 == 3'd2 || f3 == 3'd3)) f3 = F3_DIV;
			exec(enc_r(f7, pick_reg(), pick_reg(), f3, pick_reg()));
		end else if (k < 60) begin
			f3 = 3'($urandom);
			if (f3 == F3_SLTU) f3 = F3_ADD;
			if (f3 == F3_SLL || f3 == F3_SRL) begin
				f7 = (f3 == F3_SRL && $urandom_range(1) == 1) ? F7_ALT : F7_BASE;
				exec(enc_i(OP_ITYPE, {f7[6:2], 7'($urandom_range(31))} | {f7, 5'h0},
					pick_reg(), f3, pick_reg()));
			end else
				exec(enc_i(OP_ITYPE, pick_imm12(), pick_reg(), f3, pick_reg()));
		end else if (k < 72) begin
			case ($urandom_range(4))
				0: f3 = F3_LB;
				1: f3 = F3_LH;
				2: f3 = F3_LW;
				3: f3 = F3_LBU;
				default: f3 = F3_LHU;
			endcase
			exec(enc_i(OP_LOAD, pick_imm12(), pick_reg(), f3, pick_reg()));
		end else if (k < 81) begin
			exec(enc_s(pick_imm12(), pick_reg(), pick_reg(), 3'($urandom_range(2))));
		end else if (k < 87) begin
			exec(enc_b(13'($urandom), pick_reg(), pick_reg(),
				($urandom_range(1) == 1) ? F3_BNE : F3_BEQ));
		end else if (k < 90) begin
			exec(enc_j(21'($urandom), pick_reg()));
		end else if (k < 96) begin
			exec(enc_lui(($urandom_range(2) == 0) ? 20'h80000 : 20'($urandom), pick_reg()));
		end else begin
			// keep a0 on a print request so the run does not halt early
			if (sb.regs[REG_A0] != A0_PRINT_INT && sb.regs[REG_A0] != A0_PRINT_CHAR)
				exec(enc_i(OP_ITYPE, ($urandom_range(1) == 1) ? 12'd1 : 12'd11, 5'd0,
					F3_ADD, REG_A0));
			exec(ecall_word());
		end
	endtask

	task automatic write_start_pc(logic [31:0] v);
		@(negedge clk);
		in_valid <= 0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (40) @(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		sb.load_start_pc(v);
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// receiver: random stall, or one long hold-off when asked
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				out_stall <= 1;
				repeat (300) @(negedge clk);
			end else
				out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check('{status: status, next_pc: next_pc, rd: dest_register,
				value: result_value});
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [31:0] cfg_values [4];
		int halt_kind;
		sb = new();
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = '0;
		in_valid = 0;
		func = 0;
		instruction_word = '0;
		preload_address = '0;
		out_stall = 0;
		hold_req = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (6) @(negedge clk);
		arst_n = 1;

		write_start_pc(32'h0);
		// directed: extremes, every operation class, divide corner cases
		send(1, 32'hFFFF_FFFF, 16'd65532);
		send(1, 32'h0000_0000, 16'd0);
		exec(enc_lui(20'h80000, 5'd1));
		exec(enc_i(OP_ITYPE, 12'hFFF, 5'd0, F3_ADD, 5'd2));
		exec(enc_r(F7_MUL, 5'd2, 5'd1, F3_DIV, 5'd3));
		exec(enc_r(F7_MUL, 5'd2, 5'd1, F3_REM, 5'd4));
		exec(enc_r(F7_MUL, 5'd0, 5'd1, F3_DIV, 5'd5));
		exec(enc_r(F7_MUL, 5'd0, 5'd1, F3_REM, 5'd5));
		exec(enc_r(F7_MUL, 5'd0, 5'd2, F3_DIVU, 5'd6));
		exec(enc_r(F7_MUL, 5'd0, 5'd2, F3_REMU, 5'd6));
		exec(enc_r(F7_MUL, 5'd1, 5'd1, F3_MULH, 5'd7));
		exec(enc_r(F7_ALT, 5'd2, 5'd1, F3_SRL, 5'd8));
		exec(enc_r(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd0));
		exec(enc_i(OP_ITYPE, {F7_ALT, 5'd31}, 5'd1, F3_SRL, 5'd9));
		exec(enc_i(OP_LOAD, 12'hFFE, 5'd0, F3_LW, 5'd12));
		exec(enc_i(OP_LOAD, 12'hFFF, 5'd0, F3_LB, 5'd13));
		exec(enc_s(12'h7FF, 5'd1, 5'd0, F3_SW));
		exec(enc_i(OP_LOAD, 12'h7FF, 5'd0, F3_LHU, 5'd14));
		exec(enc_b(13'h1FFC, 5'd0, 5'd0, F3_BEQ));
		exec(enc_b(13'h0FFE, 5'd2, 5'd0, F3_BNE));
		exec(enc_j(21'h0FFFFE, 5'd1));
		exec(enc_i(OP_ITYPE, 12'd1, 5'd0, F3_ADD, REG_A0));
		exec(ecall_word());
		exec(enc_i(OP_ITYPE, 12'd11, 5'd0, F3_ADD, REG_A0));
		exec(ecall_word());

		cfg_values[0] = 32'hFFFF_FFFC;
		cfg_values[1] = $urandom & 32'hFFFF_FFFC;
		cfg_values[2] = $urandom & 32'hFFFF_FFFC;
		cfg_values[3] = 32'h4;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 78; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 78; end
				default: begin send_idle_pct = 20; stall_pct = 20; end
			endcase
			write_start_pc(cfg_values[ph]);
			for (int n = 0; n < 320; n++) begin
				if (ph == 0 && n == 100) hold_req = 1;
				random_word();
			end
		end

		// final halt: only one of the halting cases can be reached per run
		write_start_pc($urandom & 32'hFFFF_FFFC);
		halt_kind = $urandom_range(2);
		if (halt_kind == 0)
			exec(enc_r(F7_ALT, 5'd1, 5'd2, F3_SLL, 5'd3));
		else begin
			exec(enc_i(OP_ITYPE, (halt_kind == 1) ? A0_EXIT[11:0] : A0_PRINT_STR[11:0],
				5'd0, F3_ADD, REG_A0));
			exec(ecall_word());
		end
		for (int n = 0; n < 8; n++) begin
			if (n % 2 == 0) send(0, $urandom, 16'($urandom));
			else send(1, $urandom, 16'($urandom_range(65532)));
		end

		@(negedge clk);
		in_valid <= 0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/rvx_pkg.sv
sv/rvx_datapath.sv
sv/rvx_ctrl.sv
sv/rv32im_subset_execute_unit.sv
tb/sv/tb_rv32im_subset_execute_unit.sv
